### sv/msps_pkg.sv
// ============================================================================
// msps_pkg: shared types and constants for the Mode S preamble sync block
// Word layouts, controller/datapath link structs, register indexes, defaults.
// ============================================================================
package msps_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int SPC_REG_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 1;
    localparam int PREAMBLE_CHIPS = 16;

    // Bit k is the expected level of preamble chip k.
    localparam logic [PREAMBLE_CHIPS-1:0] PREAMBLE_PATTERN = 16'h0285;

    localparam int DEF_MAX_SPC      = 4;
    localparam int DEF_BURST_CHIPS  = 240;
    localparam int DEF_WINDOW_DEPTH = 64;

    localparam logic [SPC_REG_BITS-1:0] SPC_RESET  = 3'd2;
    localparam logic [GAIN_BITS-1:0]    GAIN_RESET = 16'd1024;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_PER_CHIP = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_GAIN   = 1'd1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] magnitude;
        logic [SAMPLE_BITS-1:0] average_level;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] chip_sample;
        logic                   burst_first;
        logic                   burst_last;
    } t_out_word;

    typedef struct packed {
        logic fire;
        logic edge_hit;
        logic peak_hit;
        logic pattern_ok;
    } t_dp_status;

    typedef struct packed {
        logic emit;
        logic first;
        logic last;
    } t_ctl_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CLIMB  = 2'd1,
        ST_BURST  = 2'd2
    } t_sync_state;

endpackage

### sv/msps_datapath.sv
// ============================================================================
// msps_datapath: sample window, edge/peak/preamble tests and output register
// Holds the look-ahead shift line and produces the status flags for the
// controller; loads a result word when the controller asks for one.
// ============================================================================
module msps_datapath #(
    parameter int MAX_SPC      = 4,
    parameter int WINDOW_DEPTH = 64,
    parameter int SPC_W        = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  msps_pkg::t_in_word            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output msps_pkg::t_out_word           o_out,
    input  logic [SPC_W-1:0]              i_spc,
    input  logic [msps_pkg::GAIN_BITS-1:0] i_gain,
    input  msps_pkg::t_ctl_cmd            i_cmd,
    output msps_pkg::t_dp_status          o_status
);
    import msps_pkg::*;

    localparam int TAPS = WINDOW_DEPTH - 1;
    localparam int TA_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PW   = SAMPLE_BITS + GAIN_BITS;

    // r_mag[j] holds the sample that sits at look-ahead j before the
    // next shift; the incoming word becomes the newest position.
    logic [SAMPLE_BITS-1:0] r_mag [TAPS];
    logic [SAMPLE_BITS-1:0] r_avg [TAPS];
    logic                   r_out_valid;
    t_out_word              r_out;

    logic                   fire;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          mag_scaled;
    logic [SAMPLE_BITS:0]   twice_slice;
    logic [SAMPLE_BITS-1:0] look [PREAMBLE_CHIPS];
    logic                   ok;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign fire        = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign prod        = PW'(r_avg[0]) * PW'(i_gain);
    assign mag_scaled  = PW'(r_mag[0]) << GAIN_FRAC_BITS;
    assign twice_slice = {1'b0, r_mag[0]} + {1'b0, r_avg[0]};

    always_comb begin
        int pos;
        pos = 0;
        for (int k = 0; k < PREAMBLE_CHIPS; k++) begin
            look[k] = '0;
            for (int s = 1; s <= MAX_SPC; s++) begin
                pos = k * s;
                if (int'(i_spc) == s) begin
                    if (pos < TAPS) begin
                        look[k] = r_mag[TA_W'(pos)];
                    end else begin
                        look[k] = i_in.magnitude;
                    end
                end
            end
        end
    end

    always_comb begin
        ok = 1'b1;
        for (int k = 0; k < PREAMBLE_CHIPS; k++) begin
            if (PREAMBLE_PATTERN[k]) begin
                ok = ok & ({look[k], 1'b0} > twice_slice);
            end else begin
                ok = ok & ({look[k], 1'b0} < twice_slice);
            end
        end
    end

    always_comb begin
        o_status.fire       = fire;
        o_status.edge_hit   = mag_scaled > prod;
        o_status.peak_hit   = r_mag[0] > r_mag[1];
        o_status.pattern_ok = ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                r_mag[j] <= '0;
                r_avg[j] <= '0;
            end
        end else if (fire) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                r_mag[j] <= r_mag[j+1];
                r_avg[j] <= r_avg[j+1];
            end
            r_mag[TAPS-1] <= i_in.magnitude;
            r_avg[TAPS-1] <= i_in.average_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_cmd.emit) begin
            r_out.chip_sample <= r_mag[0];
            r_out.burst_first <= i_cmd.first;
            r_out.burst_last  <= i_cmd.last;
        end
    end

endmodule

### sv/msps_ctrl.sv
// ============================================================================
// msps_ctrl: preamble search and burst sampling state machine
// Walks idle, rising and burst on the oldest window sample and counts the
// samples of a running burst.
// ============================================================================
module msps_ctrl #(
    parameter int MAX_SPC     = 4,
    parameter int BURST_CHIPS = 240,
    parameter int SPC_W       = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SPC_W-1:0]     i_spc,
    input  msps_pkg::t_dp_status i_status,
    output msps_pkg::t_ctl_cmd   o_cmd
);
    import msps_pkg::*;

    localparam int REM_W = $clog2(BURST_CHIPS * MAX_SPC + 1);
    localparam int PH_W  = (MAX_SPC > 1) ? $clog2(MAX_SPC) : 1;

    t_sync_state      r_state, n_state;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [REM_W-1:0] r_total, n_total;
    logic [SPC_W-1:0] r_bspc, n_bspc;
    logic [PH_W-1:0]  r_phase, n_phase;

    logic             go_rise;
    logic             start;
    logic             step;
    logic [REM_W-1:0] total_new;
    logic [REM_W-1:0] eff_rem;
    logic [REM_W-1:0] eff_total;
    logic [SPC_W-1:0] eff_bspc;
    logic [PH_W-1:0]  eff_phase;

    // Several transitions can fall on one word: an edge, the peak and a
    // preamble match all resolve in the same cycle and start the burst.
    always_comb begin
        go_rise   = ((r_state == ST_IDLE) && i_status.edge_hit) || (r_state == ST_CLIMB);
        start     = go_rise && i_status.peak_hit && i_status.pattern_ok;
        step      = start || ((r_state == ST_BURST) && (r_rem != '0));
        total_new = REM_W'(BURST_CHIPS * int'(i_spc));
        eff_rem   = start ? total_new : r_rem;
        eff_total = start ? total_new : r_total;
        eff_bspc  = start ? i_spc : r_bspc;
        eff_phase = start ? '0 : r_phase;
    end

    always_comb begin
        n_state = r_state;
        if (i_status.fire) begin
            case (r_state)
                ST_IDLE, ST_CLIMB: begin
                    if (!go_rise) begin
                        n_state = ST_IDLE;
                    end else if (!i_status.peak_hit) begin
                        n_state = ST_CLIMB;
                    end else if (i_status.pattern_ok) begin
                        n_state = ST_BURST;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_BURST: begin
                    if (r_rem == '0) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        n_rem   = r_rem;
        n_total = r_total;
        n_bspc  = r_bspc;
        n_phase = r_phase;
        if (i_status.fire && step) begin
            n_rem   = eff_rem - 1'b1;
            n_total = eff_total;
            n_bspc  = eff_bspc;
            n_phase = (eff_phase == '0) ? PH_W'(eff_bspc - 1'b1) : eff_phase - 1'b1;
        end
    end

    always_comb begin
        o_cmd.emit  = step && (eff_phase == '0);
        o_cmd.first = eff_rem == eff_total;
        o_cmd.last  = eff_rem == REM_W'(eff_bspc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rem   <= '0;
            r_total <= REM_W'(BURST_CHIPS);
            r_bspc  <= SPC_W'(1);
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
            r_total <= n_total;
            r_bspc  <= n_bspc;
            r_phase <= n_phase;
        end
    end

endmodule

### sv/mode_s_preamble_sync.sv
// ============================================================================
// mode_s_preamble_sync: Mode S preamble detector and burst chip sampler
// Finds a 16-chip preamble in a stream of magnitude samples and passes on
// one magnitude per chip for the following burst.
//
//   Channel   Signals                              Direction
//   input     i_in_valid, o_in_stall, i_in         sample word in
//   output    o_out_valid, i_out_stall, o_out      chip word out
//   config    i_cfg_we, i_cfg_index, i_cfg_data    register write
//
// One input word is taken per clock while the input is not stalled; the window
// shift, the gain multiply and the preamble compare all complete in the cycle of acceptance.
// Results trail the input by WINDOW_DEPTH-1 words, the look-ahead window.
// Synchronous reset clears the window and the state machine.
// The input stalls only while a chip word waits in the output register
// and the output side is stalled.
// ============================================================================
module mode_s_preamble_sync #(
    parameter int MAX_SPC      = msps_pkg::DEF_MAX_SPC,
    parameter int BURST_CHIPS  = msps_pkg::DEF_BURST_CHIPS,
    parameter int WINDOW_DEPTH = msps_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  msps_pkg::t_in_word                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output msps_pkg::t_out_word                o_out,
    input  logic                               i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [msps_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import msps_pkg::*;

    localparam int SPC_W = $clog2(MAX_SPC + 1);

    logic [SPC_REG_BITS-1:0] r_spc_reg;
    logic [GAIN_BITS-1:0]    r_gain;
    logic [SPC_W-1:0]        spc;
    t_dp_status              status;
    t_ctl_cmd                cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc_reg <= SPC_RESET;
            r_gain    <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLES_PER_CHIP: r_spc_reg <= i_cfg_data[SPC_REG_BITS-1:0];
                REG_THRESHOLD_GAIN:   r_gain    <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one sample per chip, anything above the maximum as the maximum.
    always_comb begin
        if (r_spc_reg == '0) begin
            spc = SPC_W'(1);
        end else if (int'(r_spc_reg) > MAX_SPC) begin
            spc = SPC_W'(MAX_SPC);
        end else begin
            spc = SPC_W'(r_spc_reg);
        end
    end

    msps_datapath #(
        .MAX_SPC      (MAX_SPC),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SPC_W        (SPC_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_spc       (spc),
        .i_gain      (r_gain),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    msps_ctrl #(
        .MAX_SPC     (MAX_SPC),
        .BURST_CHIPS (BURST_CHIPS),
        .SPC_W       (SPC_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_spc    (spc),
        .i_status (status),
        .o_cmd    (cmd)
    );

endmodule
